>>> rtl/ups_pkg.sv
// Package for the UPS status poll parser: codes, character constants and limits.
package ups_pkg;

  // Largest number of words a reply may hold before it is abandoned.
  localparam int MaxWords = 16;

  // Widths of the counters and fields.
  localparam int TickW  = 16;
  localparam int CharW  = 8;
  localparam int WordW  = 5;
  localparam int CinwW  = 4;
  localparam int CfgIdxW = 2;
  localparam int CfgDatW = 16;

  // Register indexes on the configuration port.
  localparam logic [CfgIdxW-1:0] REG_RESPONSE_TIMEOUT = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_RETRY_DELAY      = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_MAX_CHARS        = 2'd2;

  // Register reset values.
  localparam logic [TickW-1:0] RESPONSE_TIMEOUT_RST = 16'd4000;
  localparam logic [TickW-1:0] RETRY_DELAY_RST      = 16'd3000;
  localparam logic [CharW-1:0] MAX_CHARS_RST        = 8'd199;

  // Characters of interest in the reply stream.
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_Q     = 8'h51;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ONE   = 8'h31;

  // Shape of the valid status reply.
  localparam logic [WordW-1:0] STATUS_WORDS      = 5'd8;
  localparam logic [WordW-1:0] FLAG_WORD         = 5'd7;
  localparam logic [CinwW-1:0] FLAG_WORD_CHARS   = 4'd8;
  localparam logic [CinwW-1:0] CINW_MAX          = 4'd15;
  localparam logic [CinwW-1:0] POS_ON_BATTERY    = 4'd0;
  localparam logic [CinwW-1:0] POS_LOW_BATTERY   = 4'd1;
  localparam logic [CinwW-1:0] POS_FAULT         = 4'd3;
  localparam logic [CinwW-1:0] POS_OVERRIDE      = 4'd6;
  localparam logic [WordW-1:0] LAST_WORD_INDEX   = WordW'(MaxWords - 1);

  // Item kinds.
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Status codes reported to the host.
  typedef enum logic [2:0] {
    ST_UNKNOWN = 3'd0,
    ST_OK      = 3'd1,
    ST_NOLINK  = 3'd2,
    ST_BATTERY = 3'd3,
    ST_LOWBAT  = 3'd4,
    ST_FAULT   = 3'd5
  } status_t;

  // Poll sequencer phases.
  typedef enum logic [2:0] {
    PH_HOME  = 3'b001,
    PH_WAIT  = 3'b010,
    PH_DELAY = 3'b100
  } phase_t;

  // Status from the four recorded flag bits.
  function automatic status_t decode_flags(input logic [3:0] flags);
    status_t st;
    st = ST_OK;
    if (!flags[3]) begin
      if (flags[0]) begin
        st = ST_BATTERY;
      end else if (flags[1]) begin
        st = ST_LOWBAT;
      end else if (flags[2]) begin
        st = ST_FAULT;
      end
    end
    return st;
  endfunction

endpackage

>>> rtl/ups_status_poll_parser.sv
// Top level of the UPS status poll parser: input stage, parser, sequencer and result register.
// The block takes one word (a received byte or a time tick) per clock cycle while the output is
// not stalled, and gives one result word for each. A word is held in the input register and is
// parsed on its way into the result register, from which its result is on the outputs; a stall
// on the output holds both registers. Both stages hand over in the same cycle, so the sustained
// rate is one word per cycle, set by the single parse step between the two registers.
// Configuration writes take effect at once; the user must make them only while no word is in
// flight, and the block itself does not enforce this.
module ups_status_poll_parser
  import ups_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [CfgIdxW-1:0]   cfg_index,
  input  logic [CfgDatW-1:0]   cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 operation,
  input  logic [7:0]           rx_byte,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 send_query,
  output logic [2:0]           ups_status,
  output logic                 status_updated,
  output logic                 reply_done,
  output logic [WordW-1:0]     reply_words
);

  // Configuration registers.
  logic [TickW-1:0] response_timeout;
  logic [TickW-1:0] retry_delay;
  logic [CharW-1:0] max_chars;

  // Input stage.
  logic             s1_valid;
  logic             s1_op;
  logic [7:0]       s1_byte;
  logic             s1_move;

  // Parser and sequencer state.
  phase_t           phase, phase_next;
  logic [TickW-1:0] elapsed, elapsed_next;
  logic             in_reply, in_reply_next;
  logic [CharW-1:0] char_count, char_count_next;
  logic [WordW-1:0] word_index, word_index_next;
  logic [CinwW-1:0] char_in_word, char_in_word_next;
  logic [3:0]       flag_bits, flag_bits_next;
  status_t          status_reg, status_next;

  // Result fields of the word being parsed.
  logic             send_next;
  logic             upd_next;
  logic             done_next;
  logic [WordW-1:0] words_next;

  // Handshake between the stages.
  assign s1_move  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_move;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      response_timeout <= RESPONSE_TIMEOUT_RST;
      retry_delay      <= RETRY_DELAY_RST;
      max_chars        <= MAX_CHARS_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_RESPONSE_TIMEOUT: response_timeout <= cfg_data;
        REG_RETRY_DELAY:      retry_delay      <= cfg_data;
        REG_MAX_CHARS:        max_chars        <= cfg_data[CharW-1:0];
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_op   <= operation;
      s1_byte <= rx_byte;
    end
  end

  // Parse one word against the current state.
  always_comb begin
    phase_next        = phase;
    elapsed_next      = elapsed;
    in_reply_next     = in_reply;
    char_count_next   = char_count;
    word_index_next   = word_index;
    char_in_word_next = char_in_word;
    flag_bits_next    = flag_bits;
    status_next       = status_reg;
    send_next         = 1'b0;
    upd_next          = 1'b0;
    done_next         = 1'b0;
    words_next        = '0;

    if (s1_op == OP_BYTE && s1_byte == CH_NUL) begin
      // A zero byte is ignored everywhere.
    end else begin
      unique case (phase)
        PH_WAIT: begin
          if (s1_op == OP_TICK) begin
            if (elapsed >= response_timeout) begin
              status_next  = ST_NOLINK;
              upd_next     = 1'b1;
              phase_next   = PH_DELAY;
              elapsed_next = '0;
            end else begin
              elapsed_next = elapsed + 1'b1;
            end
          end else if (!in_reply) begin
            if (s1_byte == CH_OPEN) begin
              in_reply_next     = 1'b1;
              char_count_next   = '0;
              word_index_next   = '0;
              char_in_word_next = '0;
              flag_bits_next    = '0;
            end else if (s1_byte == CH_Q) begin
              send_next = 1'b1;
            end
          end else if (s1_byte == CH_CR) begin
            in_reply_next = 1'b0;
            words_next    = word_index + 1'b1;
            done_next     = 1'b1;
            if (words_next == STATUS_WORDS && char_in_word == FLAG_WORD_CHARS) begin
              status_next = decode_flags(flag_bits);
              upd_next    = 1'b1;
            end
            phase_next   = PH_DELAY;
            elapsed_next = '0;
          end else if (char_count >= max_chars) begin
            in_reply_next = 1'b0;
          end else if (s1_byte == CH_SPACE) begin
            if (word_index < LAST_WORD_INDEX) begin
              word_index_next   = word_index + 1'b1;
              char_in_word_next = '0;
              char_count_next   = char_count + 1'b1;
            end else begin
              in_reply_next = 1'b0;
            end
          end else begin
            char_count_next = char_count + 1'b1;
            if (word_index == FLAG_WORD && s1_byte == CH_ONE) begin
              case (char_in_word)
                POS_ON_BATTERY:  flag_bits_next = flag_bits | 4'b0001;
                POS_LOW_BATTERY: flag_bits_next = flag_bits | 4'b0010;
                POS_FAULT:       flag_bits_next = flag_bits | 4'b0100;
                POS_OVERRIDE:    flag_bits_next = flag_bits | 4'b1000;
                default: ;
              endcase
            end
            if (char_in_word < CINW_MAX) begin
              char_in_word_next = char_in_word + 1'b1;
            end
          end
        end
        PH_DELAY: begin
          if (s1_op == OP_TICK) begin
            if (elapsed >= retry_delay) begin
              phase_next = PH_HOME;
            end else begin
              elapsed_next = elapsed + 1'b1;
            end
          end
        end
        default: begin
          // Home: ask for a query and start waiting for the reply.
          send_next    = 1'b1;
          phase_next   = PH_WAIT;
          elapsed_next = '0;
        end
      endcase
    end
  end

  // State registers, advanced as a word passes into the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HOME;
      elapsed      <= '0;
      in_reply     <= 1'b0;
      char_count   <= '0;
      word_index   <= '0;
      char_in_word <= '0;
      flag_bits    <= '0;
      status_reg   <= ST_UNKNOWN;
    end else if (s1_move) begin
      phase        <= phase_next;
      elapsed      <= elapsed_next;
      in_reply     <= in_reply_next;
      char_count   <= char_count_next;
      word_index   <= word_index_next;
      char_in_word <= char_in_word_next;
      flag_bits    <= flag_bits_next;
      status_reg   <= status_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      send_query     <= send_next;
      ups_status     <= status_next;
      status_updated <= upd_next;
      reply_done     <= done_next;
      reply_words    <= words_next;
    end
  end

endmodule

>>> rtl/ups_chk.sv
// Port checker for the UPS status poll parser, with its bind statement.
module ups_chk
  import ups_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             out_valid,
  input logic             out_ready,
  input logic             send_query,
  input logic [2:0]       ups_status,
  input logic             status_updated,
  input logic             reply_done,
  input logic [WordW-1:0] reply_words
);

  // A word count is given only with a finished reply, and is then at least one.
  a_words_with_done: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (reply_done ? (reply_words != '0) : (reply_words == '0)))
    else $error("reply_words does not agree with reply_done");

  // An update without a finished reply can only be the timeout.
  a_timeout_nolink: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status_updated && !reply_done) |-> (ups_status == ST_NOLINK))
    else $error("status update without reply is not no link");

  // An update from a reply decodes to one of the reply codes.
  a_reply_code: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status_updated && reply_done) |->
      (ups_status == ST_OK || ups_status == ST_BATTERY ||
       ups_status == ST_LOWBAT || ups_status == ST_FAULT))
    else $error("reply update gave an unexpected status");

  // A query request never comes with a finished reply or a status update.
  a_query_alone: assert property (@(posedge clk) disable iff (rst)
    (out_valid && send_query) |-> (!reply_done && !status_updated))
    else $error("send_query raised together with reply results");

  // A stalled result word holds.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(ups_status) &&
      $stable(reply_words) && $stable(send_query)))
    else $error("stalled result word changed");

endmodule

bind ups_status_poll_parser ups_chk u_ups_chk (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .send_query     (send_query),
  .ups_status     (ups_status),
  .status_updated (status_updated),
  .reply_done     (reply_done),
  .reply_words    (reply_words)
);

>>> sim/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the UPS status poll parser, with a word-level status predictor.
module tb;
  import ups_pkg::*;

  // Characters used only by the stimulus.
  localparam logic [7:0] CH_ZERO     = 8'h30;
  localparam logic [7:0] CH_FILL     = 8'h78;
  localparam logic [7:0] CH_PRINT_LO = 8'h21;
  localparam logic [7:0] CH_PRINT_HI = 8'h7E;
  localparam logic [7:0] BYTE_MAX    = 8'hFF;

  localparam int RX_HOLD_CYCLES = 300;
  localparam int LONG_REPLY_LEN = 270;
  localparam int TICK_CLAMP     = 24;
  localparam int MAX_PRINTED    = 100;

  // One word offered to the block: a received byte or a tick.
  typedef struct packed {
    logic       op;
    logic [7:0] data;
  } poll_item_t;

  // One result word as the block should give it.
  typedef struct packed {
    logic            send;
    status_t         status;
    logic            upd;
    logic            done;
    logic [WordW-1:0] words;
  } poll_result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_wr_en = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CfgDatW-1:0] cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               operation = OP_TICK;
  logic [7:0]         rx_byte = CH_NUL;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               send_query;
  logic [2:0]         ups_status;
  logic               status_updated;
  logic               reply_done;
  logic [WordW-1:0]   reply_words;

  // Stimulus and result stores.
  poll_item_t   pending_items[$];
  poll_result_t expected_results[$];
  logic         in_taken = 1'b0;

  // Idling controls, set per phase.
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned rx_hold_seq = 0;
  int unsigned rx_hold_seen = 0;
  int unsigned rx_hold_left = 0;

  // Counters for the summary and the verdict.
  int error_count = 0;
  int items_queued = 0;
  int results_checked = 0;
  int replies_seen = 0;
  int updates_seen = 0;
  int queries_seen = 0;

  // Predictor configuration copy.
  logic [TickW-1:0] cfg_timeout = RESPONSE_TIMEOUT_RST;
  logic [TickW-1:0] cfg_delay = RETRY_DELAY_RST;
  logic [CharW-1:0] cfg_max_chars = MAX_CHARS_RST;

  // Predictor state copy.
  phase_t           poll_ph;
  logic [TickW-1:0] tick_cnt;
  logic             in_msg;
  logic [CharW-1:0] msg_chars;
  logic [WordW-1:0] word_idx;
  logic [CinwW-1:0] word_chars;
  logic [3:0]       flags;
  status_t          cur_status;

  ups_status_poll_parser dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .operation      (operation),
    .rx_byte        (rx_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .send_query     (send_query),
    .ups_status     (ups_status),
    .status_updated (status_updated),
    .reply_done     (reply_done),
    .reply_words    (reply_words)
  );

  // Clock with a 2 ns period.
  always #1 clk = ~clk;

  // Works out the result of one word and advances the predicted poller state.
  function automatic poll_result_t predict_status(logic op, logic [7:0] data);
    poll_result_t r;
    r.send  = 1'b0;
    r.upd   = 1'b0;
    r.done  = 1'b0;
    r.words = '0;
    if (op == OP_BYTE && data == CH_NUL) begin
      // Zero bytes never touch the state.
    end else if (poll_ph == PH_WAIT) begin
      if (op == OP_TICK) begin
        if (tick_cnt >= cfg_timeout) begin
          cur_status = ST_NOLINK;
          r.upd = 1'b1;
          poll_ph = PH_DELAY;
          tick_cnt = '0;
        end else begin
          tick_cnt = tick_cnt + 1'b1;
        end
      end else if (!in_msg) begin
        if (data == CH_OPEN) begin
          in_msg = 1'b1;
          msg_chars = '0;
          word_idx = '0;
          word_chars = '0;
          flags = '0;
        end else if (data == CH_Q) begin
          r.send = 1'b1;
        end
      end else if (data == CH_CR) begin
        in_msg = 1'b0;
        r.words = word_idx + 1'b1;
        r.done = 1'b1;
        if (r.words == STATUS_WORDS && word_chars == FLAG_WORD_CHARS) begin
          cur_status = flags[3] ? ST_OK :
                       flags[0] ? ST_BATTERY :
                       flags[1] ? ST_LOWBAT :
                       flags[2] ? ST_FAULT : ST_OK;
          r.upd = 1'b1;
        end
        poll_ph = PH_DELAY;
        tick_cnt = '0;
      end else if (msg_chars >= cfg_max_chars) begin
        in_msg = 1'b0;
      end else if (data == CH_SPACE) begin
        if (word_idx < LAST_WORD_INDEX) begin
          word_idx = word_idx + 1'b1;
          word_chars = '0;
          msg_chars = msg_chars + 1'b1;
        end else begin
          in_msg = 1'b0;
        end
      end else begin
        msg_chars = msg_chars + 1'b1;
        if (word_idx == FLAG_WORD && data == CH_ONE) begin
          case (word_chars)
            POS_ON_BATTERY:  flags[0] = 1'b1;
            POS_LOW_BATTERY: flags[1] = 1'b1;
            POS_FAULT:       flags[2] = 1'b1;
            POS_OVERRIDE:    flags[3] = 1'b1;
            default: ;
          endcase
        end
        if (word_chars != CINW_MAX) begin
          word_chars = word_chars + 1'b1;
        end
      end
    end else if (poll_ph == PH_DELAY) begin
      if (op == OP_TICK) begin
        if (tick_cnt >= cfg_delay) begin
          poll_ph = PH_HOME;
        end else begin
          tick_cnt = tick_cnt + 1'b1;
        end
      end
    end else begin
      r.send = 1'b1;
      poll_ph = PH_WAIT;
      tick_cnt = '0;
    end
    r.status = cur_status;
    return r;
  endfunction

  // Counts one mismatch and prints its line while no more than MAX_PRINTED have been counted.
  task automatic report_mismatch(string msg);
    error_count++;
    if (error_count <= MAX_PRINTED) begin
      $display("ERROR at %0t ns: %s", $time, msg);
    end
  endtask

  task automatic check_field(string name, int got, int want);
    if (got != want) begin
      report_mismatch($sformatf("result %0d: %s is %0d, expected %0d",
                                results_checked, name, got, want));
    end
  endtask

  // Monitor: predicts on each accepted word and checks each accepted result.
  always @(posedge clk) begin : monitor_proc
    poll_result_t want;
    if (rst) begin
      in_taken <= 1'b0;
      poll_ph = PH_HOME;
      tick_cnt = '0;
      in_msg = 1'b0;
      msg_chars = '0;
      word_idx = '0;
      word_chars = '0;
      flags = '0;
      cur_status = ST_UNKNOWN;
    end else begin
      in_taken <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        expected_results.push_back(predict_status(operation, rx_byte));
      end
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result arrived with nothing expected");
        end else begin
          want = expected_results.pop_front();
          check_field("send_query", send_query, want.send);
          check_field("ups_status", ups_status, int'(want.status));
          check_field("status_updated", status_updated, want.upd);
          check_field("reply_done", reply_done, want.done);
          check_field("reply_words", reply_words, want.words);
          results_checked++;
          replies_seen += want.done;
          updates_seen += want.upd;
          queries_seen += want.send;
        end
      end
    end
  end

  // Driver: offers the next pending word once the current one has gone.
  always @(negedge clk) begin : driver_proc
    poll_item_t it;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        it = pending_items.pop_front();
        in_valid <= 1'b1;
        operation <= it.op;
        rx_byte <= it.data;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off when one is requested.
  always @(negedge clk) begin : receiver_proc
    if (rst) begin
      out_ready <= 1'b0;
    end else if (rx_hold_seen != rx_hold_seq) begin
      rx_hold_seen <= rx_hold_seq;
      rx_hold_left <= RX_HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (rx_hold_left != 0) begin
      rx_hold_left <= rx_hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic push_item(logic op, logic [7:0] data);
    poll_item_t it;
    it.op = op;
    it.data = data;
    pending_items.push_back(it);
    items_queued++;
  endtask

  task automatic push_ticks(int n);
    for (int i = 0; i < n; i++) begin
      push_item(OP_TICK, 8'($urandom_range(255)));
    end
  endtask

  // A character inside an ordinary word, with the awkward ones mixed in.
  function automatic logic [7:0] word_char();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 4) return CH_OPEN;
    if (r < 8) return CH_Q;
    if (r < 11) return CH_NUL;
    if (r < 40) return CH_ONE;
    if (r < 55) return CH_ZERO;
    return 8'($urandom_range(CH_PRINT_LO, CH_PRINT_HI));
  endfunction

  // A reply: either a well-formed status reply or one of random shape.
  task automatic push_reply(bit well_formed);
    int nwords;
    int len;
    nwords = well_formed ? 8 : $urandom_range(1, 18);
    push_item(OP_BYTE, CH_OPEN);
    for (int w = 0; w < nwords; w++) begin
      if (w != 0) push_item(OP_BYTE, CH_SPACE);
      if (w == FLAG_WORD) begin
        len = well_formed ? 8 : $urandom_range(0, 12);
      end else if ($urandom_range(9) == 0) begin
        len = $urandom_range(10, 18);
      end else begin
        len = $urandom_range(0, 4);
      end
      for (int c = 0; c < len; c++) begin
        if (w == FLAG_WORD) begin
          push_item(OP_BYTE, $urandom_range(1) ? CH_ONE : CH_ZERO);
        end else begin
          push_item(OP_BYTE, word_char());
        end
      end
    end
    if (well_formed || $urandom_range(7) != 0) push_item(OP_BYTE, CH_CR);
  endtask

  // Random poll cycles until the given number of words is queued.
  task automatic gen_traffic(int budget);
    int start;
    int unsigned r;
    int tmo;
    int dly;
    start = items_queued;
    while (items_queued - start < budget) begin
      tmo = (cfg_timeout > TICK_CLAMP) ? TICK_CLAMP : int'(cfg_timeout);
      dly = (cfg_delay > TICK_CLAMP) ? TICK_CLAMP : int'(cfg_delay);
      r = $urandom_range(99);
      push_ticks(1);
      if ($urandom_range(3) == 0) push_item(OP_BYTE, CH_Q);
      if (r < 50) begin
        push_reply(1'b1);
        push_ticks(dly + 1);
      end else if (r < 70) begin
        push_reply(1'b0);
        push_ticks(dly + 1);
      end else if (r < 82) begin
        push_ticks(tmo + 1);
        push_ticks(dly + 1);
      end else begin
        repeat ($urandom_range(4, 16)) begin
          push_item(1'($urandom_range(1)), 8'($urandom_range(255)));
        end
      end
    end
  endtask

  task automatic cfg_write(logic [CfgIdxW-1:0] idx, logic [CfgDatW-1:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      REG_RESPONSE_TIMEOUT: cfg_timeout = val;
      REG_RETRY_DELAY:      cfg_delay = val;
      default:              cfg_max_chars = val[CharW-1:0];
    endcase
  endtask

  task automatic set_config(int tmo, int dly, int maxc);
    cfg_write(REG_RESPONSE_TIMEOUT, CfgDatW'(tmo));
    cfg_write(REG_RETRY_DELAY, CfgDatW'(dly));
    cfg_write(REG_MAX_CHARS, CfgDatW'(maxc));
    @(posedge clk);
  endtask

  // Waits until every word is through, then lets the pipeline settle.
  task automatic wait_idle();
    do begin
      @(posedge clk);
    end while (pending_items.size() != 0 || in_valid || expected_results.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // Run timeout.
  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

  // Test sequence.
  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed words: zero byte and byte in home, echo, minimal valid reply, timeout.
    set_config(2, 1, 255);
    push_item(OP_BYTE, CH_NUL);
    push_item(OP_BYTE, BYTE_MAX);
    push_item(OP_BYTE, CH_Q);
    push_item(OP_TICK, BYTE_MAX);
    push_item(OP_BYTE, CH_OPEN);
    repeat (7) push_item(OP_BYTE, CH_SPACE);
    push_item(OP_BYTE, CH_ONE);
    repeat (7) push_item(OP_BYTE, CH_ZERO);
    push_item(OP_BYTE, CH_CR);
    push_item(OP_BYTE, CH_Q);
    push_ticks(6);
    // Back to waiting, then a reply too long for the largest limit.
    push_ticks(3);
    push_item(OP_BYTE, CH_OPEN);
    for (int i = 0; i < LONG_REPLY_LEN; i++) begin
      push_item(OP_BYTE, (i % 25 == 24) ? CH_SPACE : CH_FILL);
    end
    push_item(OP_BYTE, CH_CR);
    gen_traffic(20);
    wait_idle();

    // Sender mostly idle.
    send_idle_pct = 80;
    recv_stall_pct = 0;
    set_config($urandom_range(3, 12), $urandom_range(1, 6), $urandom_range(40, 120));
    gen_traffic(50);
    wait_idle();

    // Receiver mostly stalling, with a timeout and a character limit of one.
    send_idle_pct = 0;
    recv_stall_pct = 80;
    set_config(1, 3, 1);
    gen_traffic(25);
    wait_idle();

    // Largest timeout and delay: one poll, then the block sits in its delay.
    send_idle_pct = 28;
    recv_stall_pct = 28;
    set_config(65535, 65535, 199);
    gen_traffic(15);
    wait_idle();

    // Long receiver hold-off while the sender keeps offering words.
    send_idle_pct = 0;
    recv_stall_pct = 0;
    set_config(8, 4, 120);
    rx_hold_seq++;
    gen_traffic(50);
    wait_idle();

    // Both sides idling, with a pause in the middle until all results are in.
    send_idle_pct = 28;
    recv_stall_pct = 28;
    set_config($urandom_range(1, 16), $urandom_range(1, 8), $urandom_range(30, 255));
    gen_traffic(25);
    wait_idle();
    gen_traffic(25);
    wait_idle();

    repeat (8) @(posedge clk);
    if (expected_results.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
    end
    $display("Checked %0d results for %0d words: %0d replies, %0d status updates, %0d queries.",
             results_checked, items_queued, replies_seen, updates_seen, queries_seen);
    $display("Limits ran from 1 to 65535 ticks and 1 to 255 characters under all idling patterns.");
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/ups_pkg.sv
rtl/ups_status_poll_parser.sv
rtl/ups_chk.sv
sim/tb.sv
